### design/thermistor_beta_temperature_macros.svh
// Assertion macros shared by the thermistor temperature design.
`ifndef THERMISTOR_BETA_TEMPERATURE_MACROS_SVH
`define THERMISTOR_BETA_TEMPERATURE_MACROS_SVH
// Assert that an implication holds at every clock edge outside reset.
`define TBT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Assert that a condition implies another in the next cycle.
`define TBT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

### design/tbt_pkg.sv
// Package with constants, types and helper functions for the thermistor block.
`default_nettype none
package tbt_pkg;
	localparam int LogFracBits = 16;
	localparam int LwW = 6 + LogFracBits + 2;
	localparam logic [19:0] MantMask = 20'hFFFFF;
	localparam int CommonExp = 15;
	localparam longint BetaK = 3260;
	localparam longint T0Centi = 29815;
	localparam longint KelvinCenti = 27315;
	localparam longint Ln2Q30 = 744261118;
	localparam logic signed [15:0] OutMax = 16'sd32767;
	localparam logic signed [15:0] OutMin = -16'sd27315;
	localparam longint NumVal = (BetaK * 100) << LogFracBits;
	localparam longint K0Val = (NumVal + T0Centi / 2) / T0Centi;
	localparam int NumW = 26 + LogFracBits;

	// Calibration register indexes.
	localparam logic RegOffset = 1'b0;
	localparam logic RegGain = 1'b1;

	// Result kinds decided early and carried down the pipeline.
	typedef enum logic [1:0] {
		KIND_CALC = 2'd0,
		KIND_INVALID = 2'd1,
		KIND_MIN = 2'd2
	} kind_t;

	// One squaring step of the log fraction.
	function automatic logic [30:0] sq_step(input logic [30:0] m, output logic bit_o);
		logic [61:0] p;
		logic [31:0] s;
		p = m * m;
		s = p[61:30];
		bit_o = s[31];
		sq_step = s[31] ? s[31:1] : s[30:0];
	endfunction
endpackage
`default_nettype wire

### design/tbt_log2.sv
// Pipelined base-two logarithm of a positive 36-bit value in fixed point.
`default_nettype none
module tbt_log2 import tbt_pkg::*; (
	input  wire logic clk,
	input  wire logic en,
	input  wire logic [35:0] x,
	output logic [5+LogFracBits:0] lg
);
	localparam int Steps = LogFracBits;
	logic [5:0] n_c;
	logic [30:0] m_c;
	logic [71:0] xs;
	logic [5:0] n_s [Steps+1];
	logic [30:0] m_s [Steps+1];
	logic [LogFracBits-1:0] f_s [Steps+1];

	// Find the top set bit and normalize to Q30.
	always_comb begin
		n_c = '0;
		for (int i = 0; i < 36; i++) begin
			if (x[i]) n_c = 6'(i);
		end
		xs = {36'd0, x} << 30;
		m_c = 31'(xs >> n_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s[0] <= n_c;
			m_s[0] <= m_c;
			f_s[0] <= '0;
		end
	end

	// One squaring per stage.
	for (genvar g = 0; g < Steps; g++) begin : g_sq
		logic b;
		logic [30:0] mn;
		always_comb mn = sq_step(m_s[g], b);
		always_ff @(posedge clk) begin
			if (en) begin
				n_s[g+1] <= n_s[g];
				m_s[g+1] <= mn;
				f_s[g+1] <= {f_s[g][LogFracBits-2:0], b};
			end
		end
	end

	assign lg = {n_s[Steps], f_s[Steps]};
endmodule
`default_nettype wire

### design/tbt_div.sv
// Pipelined restoring divider: one quotient bit per stage.
`default_nettype none
module tbt_div import tbt_pkg::*; (
	input  wire logic clk,
	input  wire logic en,
	input  wire logic [NumW-1:0] num,
	input  wire logic [NumW-1:0] den,
	output logic [NumW-1:0] quo
);
	logic [NumW-1:0] r_s [NumW+1];
	logic [NumW-1:0] q_s [NumW+1];
	logic [NumW-1:0] n_s [NumW+1];
	logic [NumW-1:0] d_s [NumW+1];

	always_comb begin
		r_s[0] = '0;
		q_s[0] = '0;
		n_s[0] = num;
		d_s[0] = den;
	end

	for (genvar g = 0; g < NumW; g++) begin : g_st
		logic [NumW:0] t;
		always_comb t = {r_s[g], n_s[g][NumW-1-g]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (t >= {1'b0, d_s[g]}) begin
					r_s[g+1] <= NumW'(t - {1'b0, d_s[g]});
					q_s[g+1] <= q_s[g] | (NumW'(1) << (NumW-1-g));
				end else begin
					r_s[g+1] <= NumW'(t);
					q_s[g+1] <= q_s[g];
				end
				n_s[g+1] <= n_s[g];
				d_s[g+1] <= d_s[g];
			end
		end
	end

	assign quo = q_s[NumW];
endmodule
`default_nettype wire

### design/thermistor_beta_temperature.sv
// Top level: thermistor reading to temperature, fully pipelined.
// Usage:
// An item enters on in_valid when in_stall is low and carries raw_reading.
// One result item leaves per input item on out_valid, held while out_stall.
// Results keep input order. The pipeline accepts one item every cycle while in_stall is low.
// The stages are one
// decode stage, LogFracBits + 1 logarithm stages, three stages for the log sum,
// the ln 2 product and the denominator, NumW divider stages and the output
// register. The squaring chain and the one-bit-per-stage divider set the depth.
// All stages advance together; when out_stall is high and the last stage is
// full, the whole pipe holds and in_stall is raised, so nothing is lost.
// Reset clears all valid bits and both calibration registers to zero.
// Calibration words are written through cfg_we, cfg_index and cfg_data; the user
// must write them only while no item is in flight, which the block does not enforce.
// The temperature is in hundredths of a degree Celsius, saturated.
// valid_res is low when any word is zero or the resistance is not positive.
`default_nettype none
`include "thermistor_beta_temperature_macros.svh"
module thermistor_beta_temperature import tbt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic cfg_index,
	input  wire logic [23:0] cfg_data,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [23:0] raw_reading,
	output logic out_valid,
	input  wire logic out_stall,
	output logic signed [15:0] temperature_centi,
	output logic valid_res
);
	localparam int Depth = LogFracBits + 6 + NumW;
	localparam int LgW = 6 + LogFracBits;
	logic [23:0] off_q, gain_q;
	logic en;
	logic [Depth-1:0] v_q;

	// Calibration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
			gain_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == RegGain) gain_q <= cfg_data;
			else off_q <= cfg_data;
		end
	end

	assign en = !(v_q[Depth-1] && out_stall);
	assign in_stall = !en;

	// Valid bits move with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (en) v_q <= {v_q[Depth-2:0], in_valid};
	end

	// Stage 1: decode and subtract on the common scale.
	logic [35:0] sr, so;
	logic signed [36:0] dd;
	kind_t k_c;
	always_comb begin
		sr = 36'({16'd0, raw_reading[19:0]} << (CommonExp - int'(raw_reading[23:20])));
		so = 36'({16'd0, off_q[19:0]} << (CommonExp - int'(off_q[23:20])));
		dd = $signed({1'b0, sr}) - $signed({1'b0, so});
		if (raw_reading == 0 || off_q == 0 || gain_q == 0 || dd <= 0) k_c = KIND_INVALID;
		else if ((gain_q[19:0] & MantMask) == 0) k_c = KIND_MIN;
		else k_c = KIND_CALC;
	end
	logic [35:0] d_s1;
	kind_t k_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= dd[35:0];
			k_s1 <= k_c;
		end
	end

	// Logarithms of the difference and the gain mantissa.
	logic [LgW-1:0] lgd, lgm;
	tbt_log2 u_lgd (.clk(clk), .en(en), .x(d_s1), .lg(lgd));
	tbt_log2 u_lgm (.clk(clk), .en(en), .x({16'd0, gain_q[19:0]}), .lg(lgm));
	localparam int LogW = LogFracBits + 1;
	kind_t k_d [LogW];
	always_ff @(posedge clk) begin
		if (en) begin
			k_d[0] <= k_s1;
			for (int i = 1; i < LogW; i++) k_d[i] <= k_d[i-1];
		end
	end
	// Constant log term: lg(220000) - lg(5000), computed by the same method.
	logic [LgW-1:0] lgc_a, lgc_b;
	tbt_log2 u_lga (.clk(clk), .en(en), .x(36'd220000), .lg(lgc_a));
	tbt_log2 u_lgb (.clk(clk), .en(en), .x(36'd5000), .lg(lgc_b));

	// Stage A: sum of log terms.
	logic signed [LwW-1:0] l_s2;
	kind_t k_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			l_s2 <= $signed({2'b0, lgd}) + $signed({2'b0, lgc_a}) - $signed({2'b0, lgc_b})
				- $signed({2'b0, lgm})
				+ ($signed(LwW'(int'(gain_q[23:20]) - CommonExp)) <<< LogFracBits);
			k_s2 <= k_d[LogW-1];
		end
	end

	// Stage B: multiply by ln 2.
	logic signed [LwW+31:0] p_s3;
	kind_t k_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			p_s3 <= l_s2 * $signed({1'b0, 31'(Ln2Q30)});
			k_s3 <= k_s2;
		end
	end

	// Stage C: truncate toward zero and add K0.
	logic signed [LwW+31:0] pt;
	logic signed [LwW+1:0] den_c;
	always_comb begin
		pt = p_s3;
		if (p_s3 < 0) pt = p_s3 + (LwW+32)'(64'h3FFFFFFF);
		den_c = (LwW+2)'(pt >>> 30) + (LwW+2)'(K0Val);
	end
	logic [NumW-1:0] den_s4, num_s4;
	kind_t k_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			// Only a computed item is overridden by the sign of the denominator.
			if (k_s3 != KIND_CALC) k_s4 <= k_s3;
			else if (den_c < 0) k_s4 <= KIND_MIN;
			else k_s4 <= KIND_CALC;
			den_s4 <= (den_c <= 0) ? NumW'(1) : NumW'(den_c);
			num_s4 <= (den_c == 0) ? '1
				: NumW'(NumVal) + NumW'(den_c[LwW+1:1]);
		end
	end

	// Divider stages.
	logic [NumW-1:0] q;
	tbt_div u_div (.clk(clk), .en(en), .num(num_s4), .den(den_s4), .quo(q));
	kind_t k_e [NumW];
	always_ff @(posedge clk) begin
		if (en) begin
			k_e[0] <= k_s4;
			for (int i = 1; i < NumW; i++) k_e[i] <= k_e[i-1];
		end
	end

	// Output stage: offset, saturate and choose the result.
	logic signed [NumW+1:0] t_c;
	logic signed [15:0] t_o;
	logic v_o;
	always_comb begin
		t_c = $signed({2'b0, q}) - (NumW+2)'(KelvinCenti);
		case (k_e[NumW-1])
			KIND_INVALID: begin
				t_o = '0;
				v_o = 1'b0;
			end
			KIND_MIN: begin
				t_o = OutMin;
				v_o = 1'b1;
			end
			default: begin
				v_o = 1'b1;
				if (t_c > (NumW+2)'(32767)) t_o = OutMax;
				else if (t_c < -(NumW+2)'(27315)) t_o = OutMin;
				else t_o = t_c[15:0];
			end
		endcase
	end
	always_ff @(posedge clk) begin
		if (en) begin
			temperature_centi <= t_o;
			valid_res <= v_o;
		end
	end
	assign out_valid = v_q[Depth-1];

	`TBT_ASSERT_IMP(a_stall_full, in_stall, out_valid && out_stall)
	`TBT_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid)
	`TBT_ASSERT_IMP(a_inval_zero, out_valid && !valid_res, temperature_centi == 0)
endmodule
`default_nettype wire

### sim/tb_thermistor_beta_temperature.sv
// Testbench for the thermistor temperature block: random and directed items checked in order.
`default_nettype none
module tb_thermistor_beta_temperature;
	import tbt_pkg::*;

	localparam int DRAIN_CYCLES = 120;

	typedef struct {
		logic signed [15:0] temp;
		logic valid;
	} temp_result_t;

	// Scoreboard: keeps its own copy of the calibration words and predicts each result.
	class temp_scoreboard;
		logic [23:0] offset_word;
		logic [23:0] gain_word;
		temp_result_t pending[$];
		int errors;

		function void set_reg(bit idx, logic [23:0] val);
			if (idx == RegOffset) offset_word = val;
			else gain_word = val;
		endfunction

		// Word on the common 2^-15 scale.
		function longint scaled(logic [23:0] w);
			longint v;
			v = longint'({44'd0, w[19:0]});
			return v << (CommonExp - int'(w[23:20]));
		endfunction

		// log2 of a positive integer in fixed point, by repeated squaring.
		function longint log2_fixed(longint unsigned x);
			int n;
			longint unsigned m;
			longint fr;
			n = 63;
			fr = 0;
			while (!x[n]) n--;
			m = (n <= 30) ? (x << (30 - n)) : (x >> (n - 30));
			for (int i = 0; i < LogFracBits; i++) begin
				m = (m * m) >> 30;
				fr = fr << 1;
				if (m >= (64'd2 << 30)) begin
					fr = fr | 1;
					m = m >> 1;
				end
			end
			return longint'(n) * (64'sd1 << LogFracBits) + fr;
		endfunction

		function temp_result_t predict_temp(logic [23:0] rd);
			temp_result_t r;
			longint d, l, den, q, t;
			r.temp = 16'sd0;
			r.valid = 1'b0;
			if (rd == 0 || offset_word == 0 || gain_word == 0) return r;
			d = scaled(rd) - scaled(offset_word);
			if (d <= 0) return r;
			r.valid = 1'b1;
			// Infinite resistance when the gain word holds only an exponent.
			if (gain_word[19:0] == 0) begin
				r.temp = OutMin;
				return r;
			end
			l = log2_fixed(d) + log2_fixed(220000) - log2_fixed(5000)
				- log2_fixed({44'd0, gain_word[19:0]})
				+ (longint'(gain_word[23:20]) - CommonExp) * (64'sd1 << LogFracBits);
			den = K0Val + (l * Ln2Q30) / (64'sd1 << 30);
			if (den == 0) begin
				r.temp = OutMax;
				return r;
			end
			if (den < 0) begin
				r.temp = OutMin;
				return r;
			end
			q = (NumVal + den / 2) / den;
			t = q - KelvinCenti;
			if (t > 32767) t = 32767;
			if (t < -27315) t = -27315;
			r.temp = 16'(t);
			return r;
		endfunction

		function void note_reading(logic [23:0] rd);
			pending.push_back(predict_temp(rd));
		endfunction

		function void check_result(logic signed [15:0] temp, logic vres);
			temp_result_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: temp %0d valid %0b", temp, vres);
				return;
			end
			e = pending.pop_front();
			if (temp !== e.temp || vres !== e.valid) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected temp %0d valid %0b, got temp %0d valid %0b",
						e.temp, e.valid, temp, vres);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [23:0] cfg_data = 24'd0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [23:0] raw_reading = 24'd0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] temperature_centi;
	logic valid_res;
	bit calm = 1'b0;
	temp_scoreboard sb = new();

	thermistor_beta_temperature dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .raw_reading(raw_reading),
		.out_valid(out_valid), .out_stall(out_stall),
		.temperature_centi(temperature_centi), .valid_res(valid_res)
	);

	always #10 clk = ~clk;

	// Write one calibration word while the pipeline is empty.
	task automatic write_reg(bit idx, logic [23:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	// Drive one reading after a random gap, none when calm is set, and wait until it is accepted.
	task automatic send_reading(logic [23:0] rd);
		int gap;
		bit taken;
		gap = calm ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_reading <= rd;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		sb.note_reading(rd);
	endtask

	// Drop valid right after the last accepted item and wait for the pipe to empty.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_calibration(logic [23:0] off, logic [23:0] gain);
		drain();
		write_reg(RegOffset, off);
		write_reg(RegGain, gain);
	endtask

	// A reading above the offset by the gain mantissa over a random power of two, plus up to 3.
	function automatic logic [23:0] plausible_reading();
		logic [19:0] om;
		longint unsigned m;
		om = sb.offset_word[19:0];
		m = longint'(om) + (longint'(sb.gain_word[19:0]) >> $urandom_range(0, 14))
			+ $urandom_range(0, 3);
		if (m > 20'hFFFFF) m = 20'hFFFFF;
		return {sb.offset_word[23:20], m[19:0]};
	endfunction

	// Result side: a random stall before each item, none when calm is set, then take it.
	initial begin
		int k;
		bit got;
		@(posedge arst_n);
		forever begin
			k = calm ? 0 : $urandom_range(0, 9);
			if (k > 0) begin
				out_stall <= 1'b1;
				repeat (k) @(posedge clk);
				out_stall <= 1'b0;
			end
			do begin
				@(negedge clk);
				got = out_valid && !out_stall;
				if (got) sb.check_result(temperature_centi, valid_res);
				@(posedge clk);
			end while (!got);
		end
	end

	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		logic [23:0] off, gain;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset calibration is zero: every reading is invalid.
		send_reading(24'h000001);
		send_reading(24'hFFFFFF);
		// Zero offset word, then zero gain word.
		set_calibration(24'h000000, 24'h0FFFFF);
		send_reading(24'h012345);
		set_calibration(24'h000001, 24'h000000);
		send_reading(24'h012345);
		// Extremes of the reading field, reading at or below the offset.
		set_calibration(24'h000001, 24'h0FFFFF);
		send_reading(24'h000000);
		send_reading(24'h000001);
		send_reading(24'hF00001);
		send_reading(24'h000002);
		send_reading(24'hFFFFFF);
		send_reading(24'h0FFFFF);
		send_reading(24'h8ABCDE);
		// Tiny resistance drives the denominator negative.
		set_calibration(24'hF00001, 24'h0FFFFF);
		send_reading(24'hF00002);
		send_reading(24'h000001);
		// Gain word with a zero mantissa means infinite resistance.
		set_calibration(24'h000001, 24'h100000);
		send_reading(24'h000100);
		send_reading(24'hFFFFFF);
		// Extreme calibration words.
		set_calibration(24'hFFFFFF, 24'hFFFFFF);
		send_reading(24'hFFFFFF);
		send_reading(24'h0FFFFF);
		send_reading(24'h000040);
		set_calibration(24'h000001, 24'hF00001);
		send_reading(24'h0FFFFF);
		send_reading(24'h000005);

		// Random phases, each with its own calibration.
		for (int p = 0; p < 24; p++) begin
			if ($urandom_range(0, 3) == 0) begin
				off = 24'($urandom());
				gain = 24'($urandom());
			end else begin
				off = {4'($urandom_range(0, 15)), 20'($urandom_range(1, 'h3FFFF))};
				gain = {4'($urandom_range(0, 15)), 20'($urandom_range(1, 'hFFFFF))};
			end
			set_calibration(off, gain);
			calm = (p % 6 == 5);
			for (int i = 0; i < 75; i++) begin
				if ($urandom_range(0, 9) < 7) send_reading(plausible_reading());
				else send_reading(24'($urandom()));
			end
			calm = 1'b0;
		end

		drain();
		if (sb.errors == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire
